// ----- rtl/core/slid_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sorted list insert/delete block
// no dependencies; imported by slid_store, slid_cmp and sorted_list_insert_delete
package slid_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	// fixed field widths of the stream payloads
	localparam int OP_W     = 2;
	localparam int INDEX_W  = 6;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 48;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_DEL_CMP,
		ST_RD_WAIT,
		ST_DONE
	} slid_state_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} slid_cmp_t;

endpackage

// ----- rtl/core/slid_store.sv -----
`timescale 1ns / 1ps
// entry storage: one write port, one read port with registered read data
// depends on slid_pkg for depth and widths
module slid_store
	import slid_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/slid_cmp.sv -----
`timescale 1ns / 1ps
// shared compare unit: signed greater-than and equality of a stored entry
// against the operand; depends on slid_pkg
module slid_cmp
	import slid_pkg::*;
(
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	output slid_cmp_t                res
);

	assign res.gt = (a > b);
	assign res.eq = (a == b);

endmodule

// ----- rtl/core/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// sorted list of signed values: sequencer around one entry memory and one compare unit
// insert walks the shifted entries, delete walks every held entry, an in-range read waits for read data
// one transaction is handled at a time; the next is taken once the result reaches the output register
// the walk visits one entry at a time, set by the single memory read port and compare unit
// a new transaction is taken only in idle; a finished result may wait in the output register
// reset clears the entry count and control state; entry memory is not cleared
module sorted_list_insert_delete
	import slid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,   // value[31:0], index[37:32], zero[39:38]
	input  logic [OP_W-1:0]   s_axis_tuser,   // op[1:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata    // status[1:0], removed_count[8:2],
	                                          // entry_count[15:9], read_value[47:16]
);

	slid_state_t state_q, state_d;

	logic [DATA_W-1:0] val_q, val_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  wr_q, wr_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [DATA_W-1:0] rd_q, rd_d;

	logic              m_valid_q, m_valid_d;
	logic [OUT_DW-1:0] m_data_q, m_data_d;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	slid_cmp_t         cmp;

	logic [DATA_W-1:0]  in_value;
	logic [INDEX_W-1:0] in_index;
	logic [CNT_W-1:0]   cnt_dec, ptr_dec, ptr_dec2, ptr_inc, rem_final, wr_final;
	logic               accept;

	assign in_value = s_axis_tdata[DATA_W-1:0];
	assign in_index = s_axis_tdata[DATA_W+INDEX_W-1:DATA_W];

	assign cnt_dec  = cnt_q - 1'b1;
	assign ptr_dec  = ptr_q - 1'b1;
	assign ptr_dec2 = ptr_q - CNT_W'(2);
	assign ptr_inc  = ptr_q + 1'b1;
	assign rem_final = rem_q + CNT_W'(cmp.eq);
	assign wr_final  = wr_q + CNT_W'(!cmp.eq);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	slid_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slid_cmp u_cmp (
		.a   (mem_rdata),
		.b   (val_q),
		.res (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q    <= val_d;
		ptr_q    <= ptr_d;
		wr_q     <= wr_d;
		rem_q    <= rem_d;
		status_q <= status_d;
		rd_q     <= rd_d;
		m_data_q <= m_data_d;
	end

	always_comb begin
		state_d   = state_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		wr_d      = wr_q;
		rem_d     = rem_q;
		status_d  = status_q;
		rd_d      = rd_q;
		m_valid_d = m_valid_q;
		m_data_d  = m_data_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[IDX_W-1:0];
		mem_wdata = val_q;
		mem_raddr = ptr_q[IDX_W-1:0];

		if (m_valid_q && m_axis_tready) begin
			m_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_d    = in_value;
					status_d = STAT_OK;
					rem_d    = '0;
					rd_d     = '0;
					wr_d     = '0;
					ptr_d    = cnt_q;
					state_d  = ST_DONE;
					case (s_axis_tuser)
						OP_INSERT: begin
							if (cnt_q >= CNT_W'(CAPACITY)) begin
								status_d = STAT_FULL;
							end else if (cnt_q == '0) begin
								state_d = ST_INS_PUT;
							end else begin
								mem_raddr = cnt_dec[IDX_W-1:0];
								state_d   = ST_INS_CMP;
							end
						end
						OP_DELETE: begin
							ptr_d = '0;
							if (cnt_q == '0) begin
								status_d = STAT_NOT_FOUND;
							end else begin
								mem_raddr = '0;
								state_d   = ST_DEL_CMP;
							end
						end
						OP_READ: begin
							if (CNT_W'(in_index) < cnt_q) begin
								mem_raddr = IDX_W'(in_index);
								state_d   = ST_RD_WAIT;
							end else begin
								status_d = STAT_RANGE;
							end
						end
						default: begin
							status_d = STAT_OK;
						end
					endcase
				end
			end
			ST_INS_CMP: begin
				// read data holds entry ptr-1; move it up while it is larger
				mem_we = 1'b1;
				if (cmp.gt) begin
					mem_wdata = mem_rdata;
					ptr_d     = ptr_dec;
					if (ptr_q == CNT_W'(1)) begin
						state_d = ST_INS_PUT;
					end else begin
						mem_raddr = ptr_dec2[IDX_W-1:0];
					end
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_INS_PUT: begin
				mem_we  = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				state_d = ST_DONE;
			end
			ST_DEL_CMP: begin
				// read data holds entry ptr; keep non-matching entries compacted at wr
				mem_waddr = wr_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
				mem_we    = !cmp.eq;
				rem_d     = rem_final;
				wr_d      = wr_final;
				if (ptr_inc < cnt_q) begin
					ptr_d     = ptr_inc;
					mem_raddr = ptr_inc[IDX_W-1:0];
				end else begin
					if (rem_final == '0) begin
						status_d = STAT_NOT_FOUND;
					end else begin
						cnt_d = wr_final;
					end
					state_d = ST_DONE;
				end
			end
			ST_RD_WAIT: begin
				rd_d    = mem_rdata;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					m_valid_d = 1'b1;
					m_data_d  = {rd_q, COUNT_W'(cnt_q), COUNT_W'(rem_q), status_q};
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_INS_CMP || state_q == ST_INS_PUT || state_q == ST_DEL_CMP))
		else $error("memory write outside an insert or delete walk");

	a_ins_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_CMP) |-> (ptr_q <= cnt_q && ptr_q != '0))
		else $error("insert pointer outside the list");

	a_del_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEL_CMP) |-> (wr_q <= ptr_q && ptr_q < cnt_q))
		else $error("delete write pointer ahead of read pointer");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !m_valid_q) |=> (state_q == ST_IDLE && m_valid_q))
		else $error("finished result not moved to the output register");

endmodule
